// ===== hdl/ius_pkg.sv =====
`timescale 1ns / 1ps
package ius_pkg;

  localparam int STATUS_W = 2;
  localparam int COVER_W  = 49;
  localparam int COUNT_W  = 9;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVERTED = 2'd2;

  // classification done at the front
  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_QUERY,
    KIND_BAD
  } ius_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSCAN,
    ST_SCAN1,
    ST_SCAN2,
    ST_FLUSH,
    ST_DONE
  } ius_state_t;

endpackage

// ===== hdl/ius_if.sv =====
`timescale 1ns / 1ps
interface ius_in_if #(
  parameter int ID_BITS = 48
) ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [ID_BITS-1:0] low;
  logic [ID_BITS-1:0] high;

  modport source (output valid, func, low, high, input ready);
  modport sink (input valid, func, low, high, output ready);
endinterface

interface ius_out_if ();
  logic                          valid;
  logic                          ready;
  logic [ius_pkg::STATUS_W-1:0]  status;
  logic                          member;
  logic [ius_pkg::COVER_W-1:0]   covered_count;
  logic [ius_pkg::COUNT_W-1:0]   range_count;

  modport source (output valid, status, member, covered_count, range_count, input ready);
  modport sink (input valid, status, member, covered_count, range_count, output ready);
endinterface

// ===== hdl/ius_front.sv =====
`timescale 1ns / 1ps
module ius_front #(
  parameter int ID_BITS = 48
) (
  ius_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output logic [2*ID_BITS+1:0] push_item
);

  ius_pkg::ius_kind_t kind;

  always_comb begin
    if (in_ch.func) begin
      kind = ius_pkg::KIND_QUERY;
    end else if (in_ch.low > in_ch.high) begin
      kind = ius_pkg::KIND_BAD;
    end else begin
      kind = ius_pkg::KIND_INSERT;
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_item   = {kind, in_ch.low, in_ch.high};

endmodule

// ===== hdl/ius_queue.sv =====
`timescale 1ns / 1ps
module ius_queue #(
  parameter int W = 98
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_item,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_item,
  output logic         not_empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/ius_back.sv =====
`timescale 1ns / 1ps
module ius_back #(
  parameter int MAX_RANGES = 256,
  parameter int ID_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [2*ID_BITS+1:0]          q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ius_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_member,
  output logic [ius_pkg::COVER_W-1:0]   out_covered_count,
  output logic [ius_pkg::COUNT_W-1:0]   out_range_count
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = ID_BITS + 1;
  localparam int EW = 2 * ID_BITS;
  localparam int VW = ius_pkg::COVER_W;

  // range table: start in the upper half, end in the lower half
  logic [EW-1:0] mem [MAX_RANGES];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] ra, wa;
  logic          we;
  logic [EW-1:0] wd;

  ius_pkg::ius_state_t state_r, state_nxt;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [VW-1:0]      total_r, total_nxt;
  logic [VW-1:0]      sub_r, sub_nxt;
  logic [ID_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               dv_r, dv_nxt;
  logic [CW-1:0]      w_r, w_nxt;
  logic [EW-1:0]      carry_r, carry_nxt;
  logic               carry_vld_r, carry_vld_nxt;
  logic               placed_r, placed_nxt;
  logic               absorbed_r, absorbed_nxt;
  logic               member_r, member_nxt;
  logic [ius_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ius_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                          out_member_r, out_member_nxt;
  logic [VW-1:0]                 out_cov_r, out_cov_nxt;
  logic [ius_pkg::COUNT_W-1:0]   out_rc_r, out_rc_nxt;

  ius_pkg::ius_kind_t  in_kind;
  logic [ID_BITS-1:0]  in_lo, in_hi;
  logic [ID_BITS-1:0]  ent_s, ent_e;
  logic [IW-1:0]       ent_len, new_len;
  logic [IW+VW-1:0]    ent_len_x, new_len_x;
  logic [VW-1:0]       ent_len_v, new_len_v;
  logic [CW+ius_pkg::COUNT_W-1:0] cnt_x;
  logic                scan_end;

  assign in_kind = ius_pkg::ius_kind_t'(q_item[EW+1:EW]);
  assign in_lo   = q_item[EW-1:ID_BITS];
  assign in_hi   = q_item[ID_BITS-1:0];
  assign ent_s   = rd_q[EW-1:ID_BITS];
  assign ent_e   = rd_q[ID_BITS-1:0];

  assign ent_len   = {1'b0, ent_e} - {1'b0, ent_s} + IW'(1);
  assign new_len   = {1'b0, hi_r} - {1'b0, lo_r} + IW'(1);
  assign ent_len_x = {{VW{1'b0}}, ent_len};
  assign new_len_x = {{VW{1'b0}}, new_len};
  assign ent_len_v = ent_len_x[VW-1:0];
  assign new_len_v = new_len_x[VW-1:0];
  assign cnt_x     = {{ius_pkg::COUNT_W{1'b0}}, cnt_r};

  assign scan_end = (rd_idx_r >= cnt_r) && !dv_r;
  assign ra       = rd_idx_r[AW-1:0];

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_member        = out_member_r;
  assign out_covered_count = out_cov_r;
  assign out_range_count   = out_rc_r;

  always_ff @(posedge clk) begin
    rd_q <= mem[ra];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ius_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    sub_nxt        = sub_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = 1'b0;
    w_nxt          = w_r;
    carry_nxt      = carry_r;
    carry_vld_nxt  = carry_vld_r;
    placed_nxt     = placed_r;
    absorbed_nxt   = absorbed_r;
    member_nxt     = member_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_member_nxt = out_member_r;
    out_cov_nxt    = out_cov_r;
    out_rc_nxt     = out_rc_r;
    q_pop          = 1'b0;
    we             = 1'b0;
    wa             = w_r[AW-1:0];
    wd             = rd_q;

    unique case (state_r)
      ius_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          lo_nxt       = in_lo;
          hi_nxt       = in_hi;
          rd_idx_nxt   = '0;
          sub_nxt      = '0;
          absorbed_nxt = 1'b0;
          member_nxt   = 1'b0;
          status_nxt   = ius_pkg::STATUS_OK;
          unique case (in_kind)
            ius_pkg::KIND_INSERT: state_nxt = ius_pkg::ST_SCAN1;
            ius_pkg::KIND_QUERY:  state_nxt = ius_pkg::ST_QSCAN;
            default: begin
              status_nxt = ius_pkg::STATUS_INVERTED;
              state_nxt  = ius_pkg::ST_DONE;
            end
          endcase
        end
      end

      ius_pkg::ST_QSCAN: begin
        if (rd_idx_r < cnt_r) begin
          dv_nxt     = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (dv_r && ent_s <= lo_r && lo_r <= ent_e) begin
          member_nxt = 1'b1;
        end
        if (scan_end) begin
          state_nxt = ius_pkg::ST_DONE;
        end
      end

      ius_pkg::ST_SCAN1: begin
        if (rd_idx_r < cnt_r) begin
          dv_nxt     = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        // grow the new range over every stored range that touches it
        if (dv_r && !(({1'b0, ent_e} + IW'(1)) < {1'b0, lo_r})
            && ({1'b0, ent_s} <= ({1'b0, hi_r} + IW'(1)))) begin
          absorbed_nxt = 1'b1;
          sub_nxt      = sub_r + ent_len_v;
          if (ent_s < lo_r) begin
            lo_nxt = ent_s;
          end
          if (ent_e > hi_r) begin
            hi_nxt = ent_e;
          end
        end
        if (scan_end) begin
          if (!absorbed_r && cnt_r == CW'(MAX_RANGES)) begin
            status_nxt = ius_pkg::STATUS_FULL;
            state_nxt  = ius_pkg::ST_DONE;
          end else begin
            rd_idx_nxt    = '0;
            w_nxt         = '0;
            placed_nxt    = 1'b0;
            carry_vld_nxt = 1'b0;
            state_nxt     = ius_pkg::ST_SCAN2;
          end
        end
      end

      ius_pkg::ST_SCAN2: begin
        if (rd_idx_r < cnt_r) begin
          dv_nxt     = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (dv_r) begin
          priority if (ent_e < lo_r) begin
            we    = 1'b1;
            wd    = rd_q;
            w_nxt = w_r + CW'(1);
          end else if (ent_s > hi_r) begin
            // entries after the new range move through a one-word carry
            we            = 1'b1;
            wd            = placed_r ? carry_r : {lo_r, hi_r};
            placed_nxt    = 1'b1;
            carry_nxt     = rd_q;
            carry_vld_nxt = 1'b1;
            w_nxt         = w_r + CW'(1);
          end else begin
            we = 1'b0;
          end
        end
        if (scan_end) begin
          state_nxt = ius_pkg::ST_FLUSH;
        end
      end

      ius_pkg::ST_FLUSH: begin
        we        = 1'b1;
        wd        = carry_vld_r ? carry_r : {lo_r, hi_r};
        cnt_nxt   = w_r + CW'(1);
        total_nxt = total_r - sub_r + new_len_v;
        state_nxt = ius_pkg::ST_DONE;
      end

      ius_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_member_nxt = member_r;
          out_cov_nxt    = total_r;
          out_rc_nxt     = cnt_x[ius_pkg::COUNT_W-1:0];
          state_nxt      = ius_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ius_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      total_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r        <= sub_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    rd_idx_r     <= rd_idx_nxt;
    w_r          <= w_nxt;
    carry_r      <= carry_nxt;
    carry_vld_r  <= carry_vld_nxt;
    placed_r     <= placed_nxt;
    absorbed_r   <= absorbed_nxt;
    member_r     <= member_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_member_r <= out_member_nxt;
    out_cov_r    <= out_cov_nxt;
    out_rc_r     <= out_rc_nxt;
  end

endmodule

// ===== hdl/interval_union_set.sv =====
`timescale 1ns / 1ps
// interval_union_set: sorted table of disjoint, non-adjacent inclusive ID ranges.
// in_ch takes one word per item: func 0 inserts [low, high], func 1 asks
// whether low lies in a stored range. out_ch returns one word per item:
// status, member, covered_count (IDs covered) and range_count (ranges stored).
// The front classifies each word (insert, query, inverted insert) and drops it
// into a two-deep queue; the back runs it against the one-read, one-write range memory.
// A query makes one pass over the stored ranges, an insert two (one pass to
// find what it merges, one pass to rewrite the table), a full-table drop one
// and an inverted insert none. The back returns to idle after each result
// before it pops the next word, so it works on one word at a time. The scans
// read one table entry per cycle; a word reaches the back through the
// queue's registered slots.
// Reset empties the table at once (count and total go to zero; the memory
// itself is not cleared). A result waits in the output register while
// out_ch.ready is low; the front keeps taking words until the queue is full,
// then drops in_ch.ready.
module interval_union_set #(
  parameter int MAX_RANGES = 256,
  parameter int ID_BITS    = 48
) (
  input  logic     clk,
  input  logic     rst_n,
  ius_in_if.sink   in_ch,
  ius_out_if.source out_ch
);

  localparam int IW = 2 * ID_BITS + 2;

  logic          push, q_full, q_pop, q_valid;
  logic [IW-1:0] push_item, pop_item;

  // classify and enqueue
  ius_front #(.ID_BITS(ID_BITS)) u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // hold up to two words between front and back
  ius_queue #(.W(IW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .not_empty (q_valid)
  );

  // scan, merge and compact the table; drive the result register
  ius_back #(.MAX_RANGES(MAX_RANGES), .ID_BITS(ID_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_member        (out_ch.member),
    .out_covered_count (out_ch.covered_count),
    .out_range_count   (out_ch.range_count)
  );

endmodule

// ===== hdl/ius_checker.sv =====
`timescale 1ns / 1ps
module ius_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ius_pkg::STATUS_W-1:0] out_status,
  input logic                         out_member,
  input logic [ius_pkg::COVER_W-1:0]  out_covered_count,
  input logic [ius_pkg::COUNT_W-1:0]  out_range_count
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_member) && $stable(out_covered_count) && $stable(out_range_count))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ius_pkg::STATUS_OK || out_status == ius_pkg::STATUS_FULL
      || out_status == ius_pkg::STATUS_INVERTED))
    else $error("bad status code");

  a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_member |-> out_status == ius_pkg::STATUS_OK)
    else $error("member set on failed item");

  a_member_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_member |-> out_range_count != '0 && out_covered_count != '0)
    else $error("member set with empty table");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interval_union_set ius_checker u_ius_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_member        (out_ch.member),
  .out_covered_count (out_ch.covered_count),
  .out_range_count   (out_ch.range_count)
);

// ===== bench/interval_union_set_test.sv =====
`timescale 1ns / 1ps
// Bench for interval_union_set: a directed table of inserts and queries, then
// shaped random words over three idle profiles, each result word scored
// against an in-bench copy of the range table.
module interval_union_set_test;

  localparam int          ID_BITS    = 48;
  localparam int          MAX_RANGES = 256;
  localparam logic [47:0] ID_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [48:0] ID_SPAN    = 49'h1_0000_0000_0000;
  localparam logic        FUNC_INSERT = 1'b0;
  localparam logic        FUNC_QUERY  = 1'b1;
  localparam int          CYCLE_LIMIT = 4000000;
  localparam int          DRAIN_WAIT  = 600;
  localparam int          RAND_ITEMS  = 1080;

  typedef struct packed {
    logic [ius_pkg::STATUS_W-1:0] status;
    logic                         member;
    logic [ius_pkg::COVER_W-1:0]  covered;
    logic [ius_pkg::COUNT_W-1:0]  count;
  } verdict_t;

  typedef struct packed {
    logic        func;
    logic [47:0] low;
    logic [47:0] high;
    logic        known;
    verdict_t    want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ius_in_if #(.ID_BITS(ID_BITS)) in_ch ();
  ius_out_if                     out_ch ();

  interval_union_set #(.MAX_RANGES(MAX_RANGES), .ID_BITS(ID_BITS)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the range table
  longint unsigned shadow_lo [MAX_RANGES];
  longint unsigned shadow_hi [MAX_RANGES];
  int              shadow_n;
  longint unsigned shadow_total;

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       words_scored;
  int       drops_seen;
  int       inverted_seen;
  int       hits_seen;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk the table the way the block does: find what the new range touches,
  // fold it into one slot, fix the running total.
  function automatic verdict_t table_apply(logic func, logic [47:0] low, logic [47:0] high);
    verdict_t        v;
    longint unsigned lo, hi, nlo, nhi;
    int              p, f, j, k, removed;
    bit              merged;
    lo = low;
    hi = high;
    v = '0;
    if (func == FUNC_QUERY) begin
      for (k = 0; k < shadow_n; k++)
        if (shadow_lo[k] <= lo && lo <= shadow_hi[k]) v.member = 1'b1;
    end else if (lo > hi) begin
      v.status = ius_pkg::STATUS_INVERTED;
    end else begin
      nlo = lo;
      nhi = hi;
      p = 0;
      while (p < shadow_n && shadow_lo[p] < lo) p++;
      merged = (p > 0) && (shadow_hi[p-1] + 1 >= lo);
      if (merged) begin
        nlo = shadow_lo[p-1];
        nhi = (shadow_hi[p-1] > hi) ? shadow_hi[p-1] : hi;
      end
      j = p;
      while (j < shadow_n && shadow_lo[j] <= nhi + 1) begin
        if (shadow_hi[j] > nhi) nhi = shadow_hi[j];
        j++;
      end
      f = merged ? p - 1 : p;
      removed = j - f;
      if (removed == 0 && shadow_n >= MAX_RANGES) begin
        v.status = ius_pkg::STATUS_FULL;
      end else begin
        if (removed == 0) begin
          // open a slot at f
          for (k = shadow_n; k > f; k--) begin
            shadow_lo[k] = shadow_lo[k-1];
            shadow_hi[k] = shadow_hi[k-1];
          end
          shadow_n++;
        end else begin
          for (k = f; k < j; k++) shadow_total -= shadow_hi[k] - shadow_lo[k] + 1;
          // close the gap left by absorbed ranges
          for (k = 0; k < shadow_n - j; k++) begin
            shadow_lo[f+1+k] = shadow_lo[j+k];
            shadow_hi[f+1+k] = shadow_hi[j+k];
          end
          shadow_n -= removed - 1;
        end
        shadow_lo[f] = nlo;
        shadow_hi[f] = nhi;
        shadow_total += nhi - nlo + 1;
      end
    end
    v.covered = shadow_total[ius_pkg::COVER_W-1:0];
    v.count   = shadow_n[ius_pkg::COUNT_W-1:0];
    return v;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] word %0d: %s got 0x%0h want 0x%0h", $time, words_scored, field, got, want);
    mismatches++;
  endtask

  // Offer one word; idle first if the dice say so, then hold until accepted.
  task automatic offer_word(logic func, logic [47:0] low, logic [47:0] high,
                            logic known, verdict_t want);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.low   <= low;
    in_ch.high  <= high;
    do @(posedge clk); while (!in_ch.ready);
    v = table_apply(func, low, high);
    pending_verdicts.push_back(known ? want : v);
  endtask

  task automatic park_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: score each accepted word, then pick ready for the next edge.
  initial begin
    verdict_t w;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          w = pending_verdicts.pop_front();
          if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
          if (out_ch.member !== w.member) report("member", out_ch.member, w.member);
          if (out_ch.covered_count !== w.covered)
            report("covered_count", out_ch.covered_count, w.covered);
          if (out_ch.range_count !== w.count)
            report("range_count", out_ch.range_count, w.count);
          if (w.status == ius_pkg::STATUS_FULL) drops_seen++;
          if (w.status == ius_pkg::STATUS_INVERTED) inverted_seen++;
          if (w.member) hits_seen++;
        end
        words_scored++;
      end
      // a long hold-off backs the block up into its input queue
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: drop out with a failure if the run never drains.
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d words still owed", cyc, pending_verdicts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Directed rows. Hand values only where the answer is obvious; the rest
  // go through the shadow table.
  dir_row_t dir_rows[17] = '{
    '{1'b1, 48'd0,  48'd0,  1'b1, '{ius_pkg::STATUS_OK, 1'b0, 49'd0, 9'd0}},  // empty table
    '{1'b0, 48'd5,  48'd4,  1'b1, '{ius_pkg::STATUS_INVERTED, 1'b0, 49'd0, 9'd0}},
    '{1'b0, ID_MAX, ID_MAX, 1'b1, '{ius_pkg::STATUS_OK, 1'b0, 49'd1, 9'd1}},  // top ID alone
    '{1'b1, ID_MAX, 48'd0,  1'b1, '{ius_pkg::STATUS_OK, 1'b1, 49'd1, 9'd1}},
    '{1'b0, 48'd10, 48'd20, 1'b0, '0},
    '{1'b0, 48'd22, 48'd30, 1'b0, '0},                                // gap of one
    '{1'b0, 48'd21, 48'd21, 1'b0, '0},                                // bridges both
    '{1'b0, 48'd0,  48'd9,  1'b0, '0},                                // adjacent below
    '{1'b0, 48'd40, 48'd50, 1'b0, '0},
    '{1'b0, 48'd60, 48'd70, 1'b0, '0},
    '{1'b0, 48'd35, 48'd65, 1'b0, '0},                                // swallows two
    '{1'b0, 48'd31, 48'd34, 1'b0, '0},                                // joins on both sides
    '{1'b1, 48'd71, 48'd0,  1'b0, '0},
    '{1'b1, 48'd70, ID_MAX, 1'b0, '0},
    '{1'b0, 48'd100, 48'd100, 1'b0, '0},
    '{1'b0, 48'd99, 48'd99, 1'b0, '0},                                // adjacent below
    '{1'b0, ID_MAX, 48'd0,  1'b0, '0}                                 // inverted, wide
  };

  function automatic logic [47:0] wide_id();
    return {$urandom(), $urandom()} & ID_MAX;
  endfunction

  // Mostly point and short inserts in a narrow window so the table fills,
  // merges and overflows; the rest is queries, inverted and wide noise.
  task automatic offer_random();
    int          pick;
    logic [47:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      a = 48'(4 * $urandom_range(0, 319));
      offer_word(FUNC_INSERT, a, a, 1'b0, '0);
    end else if (pick < 53) begin
      a = 48'($urandom_range(0, 1279));
      offer_word(FUNC_INSERT, a, a + 48'($urandom_range(0, 12)), 1'b0, '0);
    end else if (pick < 78) begin
      offer_word(FUNC_QUERY, 48'($urandom_range(0, 1300)), wide_id(), 1'b0, '0);
    end else if (pick < 84) begin
      a = 48'($urandom_range(1, 1300));
      offer_word(FUNC_INSERT, a, a - 48'($urandom_range(1, a)), 1'b0, '0);
    end else if (pick < 95) begin
      offer_word(1'($urandom_range(0, 1)), wide_id(), wide_id(), 1'b0, '0);
    end else begin
      offer_word(FUNC_QUERY, ID_MAX - 48'($urandom_range(0, 3)), wide_id(), 1'b0, '0);
    end
  endtask

  task automatic drain();
    park_sender();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    shadow_n      = 0;
    shadow_total  = 0;
    mismatches    = 0;
    words_scored  = 0;
    drops_seen    = 0;
    inverted_seen = 0;
    hits_seen     = 0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= 1'b0;
    in_ch.low   <= '0;
    in_ch.high  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 17; i++)
      offer_word(dir_rows[i].func, dir_rows[i].low, dir_rows[i].high,
                 dir_rows[i].known, dir_rows[i].want);
    // pause the sender until the table has answered everything
    drain();

    send_idle_pct = 13;
    recv_idle_pct = 83;
    for (i = 0; i < RAND_ITEMS / 3; i++) offer_random();
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 13;
    for (i = 0; i < RAND_ITEMS / 3; i++) offer_random();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 1500;
    for (i = 0; i < RAND_ITEMS / 3; i++) offer_random();

    // collapse everything into one range, then probe both ends
    offer_word(FUNC_INSERT, 48'd0, ID_MAX, 1'b1,
               '{ius_pkg::STATUS_OK, 1'b0, ID_SPAN, 9'd1});
    offer_word(FUNC_QUERY, 48'd0, 48'd0, 1'b1,
               '{ius_pkg::STATUS_OK, 1'b1, ID_SPAN, 9'd1});
    offer_word(FUNC_QUERY, ID_MAX, ID_MAX, 1'b1,
               '{ius_pkg::STATUS_OK, 1'b1, ID_SPAN, 9'd1});
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d result words: %0d full-table drops, %0d inverted inserts, %0d hits",
             words_scored, drops_seen, inverted_seen, hits_seen);
    $display("idle profiles 13/83, 83/13, none, plus a long receiver hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
